/* hw/rtl/bsag_pkg.sv */
// ----------------------------------------------------------------------------
// bsag_pkg
// Shared types and constants of the broadcast strided address generator:
// default sizes, offset width, operand numbering and register map.
// ----------------------------------------------------------------------------
package bsag_pkg;

   // default sizes of the walker
   localparam int DEF_MAX_AXES    = 4;
   localparam int DEF_DIM_BITS    = 16;
   localparam int DEF_STRIDE_BITS = 16;

   // fixed widths of the item fields and of the register port
   localparam int OFFSET_BITS   = 34;
   localparam int CSR_DATA_BITS = 64;
   localparam int CSR_ADDR_BITS = 6;
   localparam int RANK_BITS     = 3;
   localparam int MASK_BITS     = 4;

   // operands that carry an offset
   localparam int NUM_OPERANDS = 3;
   localparam int OPD_LHS      = 0;
   localparam int OPD_RHS      = 1;
   localparam int OPD_OUT      = 2;

   typedef logic [OFFSET_BITS-1:0] offset_type;

   // register index, taken from paddr[5:3]
   typedef enum logic [2:0] {
      REG_ACTIVE_RANK        = 3'd0,
      REG_OUT_DIMS           = 3'd1,
      REG_LHS_STRIDES        = 3'd2,
      REG_RHS_STRIDES        = 3'd3,
      REG_OUT_STRIDES        = 3'd4,
      REG_LHS_BROADCAST_MASK = 3'd5,
      REG_RHS_BROADCAST_MASK = 3'd6
   } reg_index_type;

endpackage

/* hw/rtl/bsag_regs.sv */
// ----------------------------------------------------------------------------
// bsag_regs
// Register file behind the APB-style port. Holds the shape, stride and
// broadcast registers and unpacks them into per-axis sizes and effective
// strides (zero where an operand is broadcast).
// ----------------------------------------------------------------------------
module bsag_regs
   import bsag_pkg::*;
#(
   parameter int MAX_AXES    = DEF_MAX_AXES,
   parameter int DIM_BITS    = DEF_DIM_BITS,
   parameter int STRIDE_BITS = DEF_STRIDE_BITS
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     psel,
   input  logic                     penable,
   input  logic                     pwrite,
   input  logic [CSR_ADDR_BITS-1:0] paddr,
   input  logic [CSR_DATA_BITS-1:0] pwdata,
   output logic [CSR_DATA_BITS-1:0] prdata,
   output logic                     pready,
   output logic                     cfg_write,
   output logic [MAX_AXES-1:0]      axis_active,
   output logic [DIM_BITS-1:0]      dims [MAX_AXES],
   output logic [STRIDE_BITS-1:0]   eff_stride [NUM_OPERANDS][MAX_AXES]
);

   localparam int DIM_PAD_BITS    = CSR_DATA_BITS + MAX_AXES * DIM_BITS;
   localparam int STRIDE_PAD_BITS = CSR_DATA_BITS + MAX_AXES * STRIDE_BITS;

   logic [RANK_BITS-1:0]     active_rank_ff;
   logic [CSR_DATA_BITS-1:0] out_dims_ff;
   logic [CSR_DATA_BITS-1:0] lhs_strides_ff;
   logic [CSR_DATA_BITS-1:0] rhs_strides_ff;
   logic [CSR_DATA_BITS-1:0] out_strides_ff;
   logic [MASK_BITS-1:0]     lhs_mask_ff;
   logic [MASK_BITS-1:0]     rhs_mask_ff;

   reg_index_type            reg_sel;

   logic [DIM_PAD_BITS-1:0]    dims_pad;
   logic [STRIDE_PAD_BITS-1:0] stride_pad [NUM_OPERANDS];

   assign pready    = 1'b1;
   assign reg_sel   = reg_index_type'(paddr[5:3]);
   assign cfg_write = psel & penable & pwrite;

   // register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         active_rank_ff <= '0;
         out_dims_ff    <= '0;
         lhs_strides_ff <= '0;
         rhs_strides_ff <= '0;
         out_strides_ff <= '0;
         lhs_mask_ff    <= '0;
         rhs_mask_ff    <= '0;
      end else if (cfg_write) begin
         unique case (reg_sel)
            REG_ACTIVE_RANK:        active_rank_ff <= pwdata[RANK_BITS-1:0];
            REG_OUT_DIMS:           out_dims_ff    <= pwdata;
            REG_LHS_STRIDES:        lhs_strides_ff <= pwdata;
            REG_RHS_STRIDES:        rhs_strides_ff <= pwdata;
            REG_OUT_STRIDES:        out_strides_ff <= pwdata;
            REG_LHS_BROADCAST_MASK: lhs_mask_ff    <= pwdata[MASK_BITS-1:0];
            REG_RHS_BROADCAST_MASK: rhs_mask_ff    <= pwdata[MASK_BITS-1:0];
            default: ;
         endcase
      end
   end

   // read back
   always_comb begin
      unique case (reg_sel)
         REG_ACTIVE_RANK:        prdata = CSR_DATA_BITS'(active_rank_ff);
         REG_OUT_DIMS:           prdata = out_dims_ff;
         REG_LHS_STRIDES:        prdata = lhs_strides_ff;
         REG_RHS_STRIDES:        prdata = rhs_strides_ff;
         REG_OUT_STRIDES:        prdata = out_strides_ff;
         REG_LHS_BROADCAST_MASK: prdata = CSR_DATA_BITS'(lhs_mask_ff);
         REG_RHS_BROADCAST_MASK: prdata = CSR_DATA_BITS'(rhs_mask_ff);
         default:                prdata = '0;
      endcase
   end

   // slots past the top of a register read as zero
   assign dims_pad            = {{(MAX_AXES*DIM_BITS){1'b0}}, out_dims_ff};
   assign stride_pad[OPD_LHS] = {{(MAX_AXES*STRIDE_BITS){1'b0}}, lhs_strides_ff};
   assign stride_pad[OPD_RHS] = {{(MAX_AXES*STRIDE_BITS){1'b0}}, rhs_strides_ff};
   assign stride_pad[OPD_OUT] = {{(MAX_AXES*STRIDE_BITS){1'b0}}, out_strides_ff};

   // per-axis unpacking, rank clamped by the axis count
   for (genvar s = 0; s < MAX_AXES; s++) begin : g_axis
      logic lhs_bcast;
      logic rhs_bcast;

      if (s < MASK_BITS) begin : g_mask
         assign lhs_bcast = lhs_mask_ff[s];
         assign rhs_bcast = rhs_mask_ff[s];
      end else begin : g_nomask
         assign lhs_bcast = 1'b0;
         assign rhs_bcast = 1'b0;
      end

      assign axis_active[s] = ({1'b0, active_rank_ff} > (RANK_BITS+1)'(s));
      assign dims[s]        = dims_pad[s*DIM_BITS +: DIM_BITS];

      assign eff_stride[OPD_LHS][s] =
         lhs_bcast ? '0 : stride_pad[OPD_LHS][s*STRIDE_BITS +: STRIDE_BITS];
      assign eff_stride[OPD_RHS][s] =
         rhs_bcast ? '0 : stride_pad[OPD_RHS][s*STRIDE_BITS +: STRIDE_BITS];
      assign eff_stride[OPD_OUT][s] = stride_pad[OPD_OUT][s*STRIDE_BITS +: STRIDE_BITS];
   end

endmodule

/* hw/rtl/broadcast_strided_address_generator_unit.sv */
// ----------------------------------------------------------------------------
// broadcast_strided_address_generator_unit
// Walks an output tensor in row-major order and issues, per item, the element
// offsets of the left operand, the right operand and the output.
// ----------------------------------------------------------------------------
// Usage
//   Program the shape, strides and broadcast masks through the APB-style port
//   while the block is idle. Each request item carries restart: 1 starts the
//   walk at the first element, 0 moves on to the next one. Every request item
//   gives exactly one response item with the three offsets, element_valid and
//   last (set on the final element). Once the walk is over, or for an empty
//   tensor, responses carry element_valid low and zero fields until a restart.
//   The response is registered in the output register. One item is taken
//   every cycle unless a rebuild runs or the skid is occupied. Per axis the
//   block keeps a coordinate counter and, per operand, the offset that a
//   carry into that axis lands on, so one step is a priority pick and one add.
//   After any register write the block rebuilds those landing offsets with
//   one multiplier per operand, one axis at a time, and holds req_stall high
//   meanwhile.
//   Reset clears the registers and leaves the walk finished, so nothing but
//   invalid responses come out before the first restart. A response waits in
//   the output register while rsp_stall is high; a second item goes into a
//   skid register, and under back-pressure req_stall rises only while that
//   skid is occupied.
// ----------------------------------------------------------------------------
module broadcast_strided_address_generator_unit
   import bsag_pkg::*;
#(
   parameter int MAX_AXES    = DEF_MAX_AXES,
   parameter int DIM_BITS    = DEF_DIM_BITS,
   parameter int STRIDE_BITS = DEF_STRIDE_BITS
) (
   input  logic                     clock,
   input  logic                     reset,
   // request channel
   input  logic                     req_valid,
   output logic                     req_stall,
   input  logic                     req_restart,
   // response channel
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic [OFFSET_BITS-1:0]   rsp_lhs_offset,
   output logic [OFFSET_BITS-1:0]   rsp_rhs_offset,
   output logic [OFFSET_BITS-1:0]   rsp_out_offset,
   output logic                     rsp_element_valid,
   output logic                     rsp_last,
   // register port
   input  logic                     psel,
   input  logic                     penable,
   input  logic                     pwrite,
   input  logic [CSR_ADDR_BITS-1:0] paddr,
   input  logic [CSR_DATA_BITS-1:0] pwdata,
   output logic [CSR_DATA_BITS-1:0] prdata,
   output logic                     pready
);

   localparam int IDX_BITS  = (MAX_AXES > 1) ? $clog2(MAX_AXES) : 1;
   localparam int PROD_BITS = DIM_BITS + STRIDE_BITS;

   typedef struct packed {
      offset_type lhs_ofs;
      offset_type rhs_ofs;
      offset_type out_ofs;
      logic       element_valid;
      logic       last;
   } rsp_item_type;

   typedef enum logic [1:0] {
      RF_IDLE,
      RF_MUL,
      RF_SUB
   } refresh_state_type;

   // configuration
   logic                   cfg_write;
   logic [MAX_AXES-1:0]    axis_active;
   logic [DIM_BITS-1:0]    dims [MAX_AXES];
   logic [STRIDE_BITS-1:0] eff_stride [NUM_OPERANDS][MAX_AXES];

   // walk state
   logic [DIM_BITS-1:0]    coord_ff [MAX_AXES];
   logic [DIM_BITS-1:0]    coord_in [MAX_AXES];
   offset_type             offset_ff [NUM_OPERANDS];
   offset_type             offset_in [NUM_OPERANDS];
   offset_type             landing_ff [NUM_OPERANDS][MAX_AXES];
   offset_type             landing_in [NUM_OPERANDS][MAX_AXES];
   logic                   finished_ff;
   logic                   finished_in;

   // landing offset rebuild
   refresh_state_type      refresh_ff;
   logic [IDX_BITS-1:0]    sweep_idx_ff;
   offset_type             sweep_acc_ff [NUM_OPERANDS];
   offset_type             sweep_prod_ff [NUM_OPERANDS];
   logic [PROD_BITS-1:0]   sweep_prod [NUM_OPERANDS];

   // step logic
   logic                   accept;
   logic                   any_dim_zero;
   logic                   fin_cur;
   logic [DIM_BITS-1:0]    coord_cur [MAX_AXES];
   logic [DIM_BITS:0]      coord_inc [MAX_AXES];
   offset_type             offset_cur [NUM_OPERANDS];
   offset_type             landing_cur [NUM_OPERANDS][MAX_AXES];
   offset_type             landing_sel [NUM_OPERANDS];
   logic [MAX_AXES-1:0]    wrap;
   logic [MAX_AXES-1:0]    land;
   logic [MAX_AXES-1:0]    clear;
   logic [MAX_AXES-1:0]    at_or_below;
   logic                   carry;
   logic                   above;
   logic                   carried;
   rsp_item_type           step_item;

   // output register and skid
   logic                   out_valid_ff;
   rsp_item_type           out_item_ff;
   logic                   skid_valid_ff;
   rsp_item_type           skid_item_ff;
   logic                   out_take;

   bsag_regs #(
      .MAX_AXES    (MAX_AXES),
      .DIM_BITS    (DIM_BITS),
      .STRIDE_BITS (STRIDE_BITS)
   ) u_regs (
      .clock       (clock),
      .reset       (reset),
      .psel        (psel),
      .penable     (penable),
      .pwrite      (pwrite),
      .paddr       (paddr),
      .pwdata      (pwdata),
      .prdata      (prdata),
      .pready      (pready),
      .cfg_write   (cfg_write),
      .axis_active (axis_active),
      .dims        (dims),
      .eff_stride  (eff_stride)
   );

   // handshakes
   assign req_stall = skid_valid_ff | (refresh_ff != RF_IDLE);
   assign accept    = req_valid & ~req_stall;
   assign out_take  = out_valid_ff & ~rsp_stall;

   // empty tensor check for a restart
   always_comb begin
      any_dim_zero = 1'b0;
      for (int s = 0; s < MAX_AXES; s++) begin
         if (axis_active[s] && (dims[s] == '0)) begin
            any_dim_zero = 1'b1;
         end
      end
   end

   // one step: pick the axis the carry lands on and move there
   always_comb begin
      fin_cur = req_restart ? any_dim_zero : finished_ff;

      for (int s = 0; s < MAX_AXES; s++) begin
         coord_cur[s] = req_restart ? '0 : coord_ff[s];
         coord_inc[s] = {1'b0, coord_cur[s]} + (DIM_BITS+1)'(1);
         wrap[s]      = (coord_inc[s] >= {1'b0, dims[s]});
      end

      for (int o = 0; o < NUM_OPERANDS; o++) begin
         offset_cur[o] = req_restart ? '0 : offset_ff[o];
         for (int s = 0; s < MAX_AXES; s++) begin
            landing_cur[o][s] = req_restart ? OFFSET_BITS'(eff_stride[o][s])
                                            : landing_ff[o][s];
         end
      end

      // lowest active axis that does not wrap
      carry = 1'b1;
      for (int s = 0; s < MAX_AXES; s++) begin
         land[s]  = axis_active[s] & carry & ~wrap[s];
         clear[s] = axis_active[s] & carry & wrap[s];
         carry    = carry & wrap[s];
      end
      carried = ~|land;

      // axes at or below the landing axis
      above = 1'b0;
      for (int s = MAX_AXES - 1; s >= 0; s--) begin
         above          = above | land[s];
         at_or_below[s] = above;
      end

      for (int o = 0; o < NUM_OPERANDS; o++) begin
         landing_sel[o] = '0;
         for (int s = 0; s < MAX_AXES; s++) begin
            if (land[s]) begin
               landing_sel[o] = landing_cur[o][s];
            end
         end
      end

      coord_in    = coord_cur;
      offset_in   = offset_cur;
      landing_in  = landing_cur;
      finished_in = fin_cur;

      if (!fin_cur) begin
         for (int s = 0; s < MAX_AXES; s++) begin
            if (land[s]) begin
               coord_in[s] = coord_inc[s][DIM_BITS-1:0];
            end else if (clear[s]) begin
               coord_in[s] = '0;
            end
         end
         for (int o = 0; o < NUM_OPERANDS; o++) begin
            if (!carried) begin
               offset_in[o] = landing_sel[o];
            end
            for (int s = 0; s < MAX_AXES; s++) begin
               if (at_or_below[s]) begin
                  landing_in[o][s] = landing_sel[o] + OFFSET_BITS'(eff_stride[o][s]);
               end
            end
         end
         finished_in = carried;
      end

      step_item.lhs_ofs       = fin_cur ? '0 : offset_cur[OPD_LHS];
      step_item.rhs_ofs       = fin_cur ? '0 : offset_cur[OPD_RHS];
      step_item.out_ofs       = fin_cur ? '0 : offset_cur[OPD_OUT];
      step_item.element_valid = ~fin_cur;
      step_item.last          = ~fin_cur & carried;
   end

   // products for the axis being rebuilt
   always_comb begin
      for (int o = 0; o < NUM_OPERANDS; o++) begin
         sweep_prod[o] = PROD_BITS'(coord_ff[sweep_idx_ff]) *
                         PROD_BITS'(eff_stride[o][sweep_idx_ff]);
      end
   end

   // control state: walk position and rebuild sequencer
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int s = 0; s < MAX_AXES; s++) begin
            coord_ff[s] <= '0;
         end
         for (int o = 0; o < NUM_OPERANDS; o++) begin
            offset_ff[o] <= '0;
         end
         finished_ff  <= 1'b1;
         refresh_ff   <= RF_IDLE;
         sweep_idx_ff <= '0;
      end else if (cfg_write) begin
         refresh_ff   <= RF_MUL;
         sweep_idx_ff <= '0;
      end else begin
         unique case (refresh_ff)
            RF_IDLE: begin
               if (accept) begin
                  coord_ff    <= coord_in;
                  offset_ff   <= offset_in;
                  finished_ff <= finished_in;
               end
            end
            RF_MUL: begin
               refresh_ff <= RF_SUB;
            end
            RF_SUB: begin
               if (sweep_idx_ff == IDX_BITS'(MAX_AXES - 1)) begin
                  refresh_ff <= RF_IDLE;
               end else begin
                  sweep_idx_ff <= sweep_idx_ff + IDX_BITS'(1);
                  refresh_ff   <= RF_MUL;
               end
            end
            default: refresh_ff <= RF_IDLE;
         endcase
      end
   end

   // landing offsets: rebuilt after a register write, moved on every step
   always_ff @(posedge clock) begin
      if (cfg_write) begin
         sweep_acc_ff <= offset_ff;
      end else if (refresh_ff == RF_MUL) begin
         for (int o = 0; o < NUM_OPERANDS; o++) begin
            landing_ff[o][sweep_idx_ff] <= sweep_acc_ff[o] +
                                           OFFSET_BITS'(eff_stride[o][sweep_idx_ff]);
            sweep_prod_ff[o]            <= OFFSET_BITS'(sweep_prod[o]);
         end
      end else if (refresh_ff == RF_SUB) begin
         for (int o = 0; o < NUM_OPERANDS; o++) begin
            sweep_acc_ff[o] <= sweep_acc_ff[o] - sweep_prod_ff[o];
         end
      end else if (accept) begin
         landing_ff <= landing_in;
      end
   end

   // output register with skid
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (skid_valid_ff) begin
         if (out_take) begin
            skid_valid_ff <= 1'b0;
         end
      end else if (accept) begin
         if (out_valid_ff && !out_take) begin
            skid_valid_ff <= 1'b1;
         end else begin
            out_valid_ff <= 1'b1;
         end
      end else if (out_take) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (skid_valid_ff && out_take) begin
         out_item_ff <= skid_item_ff;
      end else if (accept && !skid_valid_ff) begin
         if (out_valid_ff && !out_take) begin
            skid_item_ff <= step_item;
         end else begin
            out_item_ff <= step_item;
         end
      end
   end

   assign rsp_valid         = out_valid_ff;
   assign rsp_lhs_offset    = out_item_ff.lhs_ofs;
   assign rsp_rhs_offset    = out_item_ff.rhs_ofs;
   assign rsp_out_offset    = out_item_ff.out_ofs;
   assign rsp_element_valid = out_item_ff.element_valid;
   assign rsp_last          = out_item_ff.last;

   // the skid only ever holds an item behind a waiting output item
   a_skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid item without an output item");

   // no item is taken while the landing offsets are being rebuilt
   a_no_accept_in_refresh: assert property (@(posedge clock) disable iff (reset)
      (refresh_ff != RF_IDLE) |-> !accept)
      else $error("item accepted during rebuild");

   // an item flagged last closes the walk
   a_last_finishes: assert property (@(posedge clock) disable iff (reset)
      (accept && step_item.last) |=> finished_ff)
      else $error("walk still open after its last element");

   // a response without an element carries zero offsets and no last flag
   a_invalid_is_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_element_valid) |->
         (rsp_lhs_offset == '0 && rsp_rhs_offset == '0 &&
          rsp_out_offset == '0 && !rsp_last))
      else $error("empty response with non-zero fields");

   // a register write always starts a rebuild
   a_write_starts_refresh: assert property (@(posedge clock) disable iff (reset)
      cfg_write |=> (refresh_ff == RF_MUL && sweep_idx_ff == '0))
      else $error("register write without a rebuild");

endmodule
